// ----- hdl/pwgm_pkg.sv -----
// shared constants, types and register codes for the prewitt gradient magnitude block
`timescale 1ns / 1ps

package pwgm_pkg;

    // field and register widths
    localparam int PIX_W     = 8;
    localparam int GRAD_W    = 11;
    localparam int MAG_W     = 11;
    localparam int BYTE_W    = 8;
    localparam int CFG_WID_W = 11;
    localparam int CFG_HGT_W = 16;
    localparam int SUM_W     = 21;
    localparam int APB_A_W   = 3;
    localparam int APB_D_W   = 32;

    // default line length of the line store
    localparam int MAX_WIDTH_DEF = 1024;

    // register reset values
    localparam logic [CFG_WID_W-1:0] WIDTH_RST  = 11'd640;
    localparam logic [CFG_HGT_W-1:0] HEIGHT_RST = 16'd480;

    // register indexes, taken from paddr[2]
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_WIN,
        S_GRAD,
        S_SQUARE,
        S_ROOT_GO,
        S_ROOT,
        S_LOAD
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic accept;
        logic win;
        logic grad;
        logic square;
        logic root_go;
        logic load;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic emit;
        logic root_done;
        logic out_free;
    } t_stat;

endpackage

// ----- hdl/pwgm_isqrt.sv -----
// iterative integer square root, one result bit per cycle
`timescale 1ns / 1ps

module pwgm_isqrt
    import pwgm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SUM_W-1:0]  i_radicand,
    output logic              o_done,
    output logic [MAG_W-1:0]  o_root
);

    localparam int RW    = SUM_W + 1;
    localparam int CNT_W = $clog2(MAG_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(MAG_W - 1);

    logic            r_busy;
    logic            r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [RW-1:0]   r_v;
    logic [RW-1:0]   r_res;
    logic [RW-1:0]   r_bit;
    logic [RW-1:0]   n_v;
    logic [RW-1:0]   n_res;
    logic [RW-1:0]   trial;

    // one restoring step
    always_comb begin
        trial = r_res + r_bit;
        if (r_v >= trial) begin
            n_v   = r_v - trial;
            n_res = (r_res >> 1) + r_bit;
        end else begin
            n_v   = r_v;
            n_res = r_res >> 1;
        end
    end

    // control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == LAST);
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == LAST)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= RW'(i_radicand);
            r_res <= '0;
            r_bit <= RW'(1) << (2 * (MAG_W - 1));
            r_cnt <= '0;
        end else if (r_busy) begin
            r_v   <= n_v;
            r_res <= n_res;
            r_bit <= r_bit >> 2;
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[MAG_W-1:0];

endmodule

// ----- hdl/pwgm_dpath.sv -----
// datapath: line store, 3x3 window, prewitt sums, squares, root and output register
`timescale 1ns / 1ps

module pwgm_dpath
    import pwgm_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    output t_stat                   o_stat,
    input  logic                    i_restart,
    input  logic [CFG_WID_W-1:0]    i_cfg_width,
    input  logic [CFG_HGT_W-1:0]    i_cfg_height,
    input  logic [PIX_W-1:0]        i_pixel,
    input  logic                    i_out_ready,
    output logic                    o_out_valid,
    output logic signed [GRAD_W-1:0] o_grad_x,
    output logic signed [GRAD_W-1:0] o_grad_y,
    output logic [MAG_W-1:0]        o_magnitude,
    output logic [BYTE_W-1:0]       o_magnitude_byte,
    output logic                    o_frame_end
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int CS = PIX_W + 2;

    logic [2*PIX_W-1:0] r_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] r_rd;
    logic [PIX_W-1:0]   r_pix;
    logic [PIX_W-1:0]   r_win [3][3];
    logic [CW-1:0]      r_col;
    logic [CFG_HGT_W-1:0] r_row;
    logic               r_fe;
    logic signed [GRAD_W-1:0] r_gx;
    logic signed [GRAD_W-1:0] r_gy;
    logic [SUM_W-1:0]   r_sum;
    logic               r_out_valid;
    logic signed [GRAD_W-1:0] r_o_gx;
    logic signed [GRAD_W-1:0] r_o_gy;
    logic [MAG_W-1:0]   r_o_mag;
    logic [BYTE_W-1:0]  r_o_byte;
    logic               r_o_fe;

    logic [31:0]        w_raw;
    logic [31:0]        w_eff32;
    logic [WW-1:0]      w_eff;
    logic [CFG_HGT_W-1:0] h_eff;
    logic               col_last;
    logic               row_last;
    logic               emit;
    logic [CS-1:0]      s_left, s_right, s_top, s_bot;
    logic signed [GRAD_W-1:0] gx, gy;
    logic signed [2*GRAD_W-1:0] sq_x, sq_y;
    logic               root_done;
    logic [MAG_W-1:0]   root;

    // effective frame size
    assign w_raw = 32'(i_cfg_width);
    always_comb begin
        if (w_raw < 32'd3) begin
            w_eff32 = 32'd3;
        end else if (w_raw > 32'(MAX_WIDTH)) begin
            w_eff32 = 32'(MAX_WIDTH);
        end else begin
            w_eff32 = w_raw;
        end
    end
    assign w_eff = w_eff32[WW-1:0];
    assign h_eff = (i_cfg_height < 16'd3) ? 16'd3 : i_cfg_height;

    assign col_last = (WW'(r_col) == (w_eff - WW'(1)));
    assign row_last = (r_row == (h_eff - 16'd1));
    assign emit     = (r_row >= 16'd2) && (r_col >= CW'(2));

    // line store: two rows packed per entry, upper byte is the older row
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rd <= r_mem[r_col];
        end
        if (i_cmd.win) begin
            r_mem[r_col] <= {r_rd[PIX_W-1:0], r_pix};
        end
    end

    // pixel capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pix <= i_pixel;
        end
    end

    // window shift and raster counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_fe  <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[k][j] <= '0;
                end
            end
        end else if (i_restart) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cmd.win) begin
            for (int k = 0; k < 3; k++) begin
                r_win[k][0] <= r_win[k][1];
                r_win[k][1] <= r_win[k][2];
            end
            r_win[0][2] <= r_rd[2*PIX_W-1:PIX_W];
            r_win[1][2] <= r_rd[PIX_W-1:0];
            r_win[2][2] <= r_pix;
            r_fe <= row_last && col_last;
            if (col_last) begin
                r_col <= '0;
                r_row <= row_last ? '0 : r_row + 16'd1;
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // prewitt column and row sums
    always_comb begin
        s_left  = CS'(r_win[0][0]) + CS'(r_win[1][0]) + CS'(r_win[2][0]);
        s_right = CS'(r_win[0][2]) + CS'(r_win[1][2]) + CS'(r_win[2][2]);
        s_top   = CS'(r_win[0][0]) + CS'(r_win[0][1]) + CS'(r_win[0][2]);
        s_bot   = CS'(r_win[2][0]) + CS'(r_win[2][1]) + CS'(r_win[2][2]);
        gx = $signed({1'b0, s_right}) - $signed({1'b0, s_left});
        gy = $signed({1'b0, s_top}) - $signed({1'b0, s_bot});
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.grad) begin
            r_gx <= gx;
            r_gy <= gy;
        end
    end

    // squares and their sum
    assign sq_x = r_gx * r_gx;
    assign sq_y = r_gy * r_gy;

    always_ff @(posedge i_clk) begin
        if (i_cmd.square) begin
            r_sum <= SUM_W'(sq_x[SUM_W-2:0]) + SUM_W'(sq_y[SUM_W-2:0]);
        end
    end

    // square root unit
    pwgm_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.root_go),
        .i_radicand (r_sum),
        .o_done     (root_done),
        .o_root     (root)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_o_gx   <= r_gx;
            r_o_gy   <= r_gy;
            r_o_mag  <= root;
            r_o_byte <= (root > MAG_W'(255)) ? 8'hFF : root[BYTE_W-1:0];
            r_o_fe   <= r_fe;
        end
    end

    // status to the controller
    assign o_stat.emit      = emit;
    assign o_stat.root_done = root_done;
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid      = r_out_valid;
    assign o_grad_x         = r_o_gx;
    assign o_grad_y         = r_o_gy;
    assign o_magnitude      = r_o_mag;
    assign o_magnitude_byte = r_o_byte;
    assign o_frame_end      = r_o_fe;

endmodule

// ----- hdl/pwgm_ctrl.sv -----
// controller state machine sequencing one pixel request through the datapath
`timescale 1ns / 1ps

module pwgm_ctrl
    import pwgm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_WIN;
            end
            S_WIN: begin
                n_state = i_stat.emit ? S_GRAD : S_IDLE;
            end
            S_GRAD:    n_state = S_SQUARE;
            S_SQUARE:  n_state = S_ROOT_GO;
            S_ROOT_GO: n_state = S_ROOT;
            S_ROOT: begin
                if (i_stat.root_done) n_state = S_LOAD;
            end
            S_LOAD: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            S_WIN:     o_cmd.win     = 1'b1;
            S_GRAD:    o_cmd.grad    = 1'b1;
            S_SQUARE:  o_cmd.square  = 1'b1;
            S_ROOT_GO: o_cmd.root_go = 1'b1;
            S_ROOT: begin
            end
            S_LOAD:    o_cmd.load    = i_stat.out_free;
            default: begin
            end
        endcase
    end

endmodule

// ----- hdl/prewitt_gradient_magnitude_top.sv -----
// top level: configuration registers, controller and datapath of the prewitt magnitude block
// a border pixel passes the window state and returns to idle, ready again; an interior pixel goes on
// through the gradient, square, root start, root and load states, the load waiting for a free output
// register, before the next request; the 11-step iterative square root follows the window and square stages
// synchronous active-low reset: width 640, height 480, counters and window zero;
// the line store holds no reset and needs no clearing pass; any register write restarts the frame
`timescale 1ns / 1ps

module prewitt_gradient_magnitude_top
    import pwgm_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_A_W-1:0]       paddr,
    input  logic [APB_D_W-1:0]       pwdata,
    output logic [APB_D_W-1:0]       prdata,
    output logic                     pready,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [PIX_W-1:0]         i_pixel,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [GRAD_W-1:0] o_grad_x,
    output logic signed [GRAD_W-1:0] o_grad_y,
    output logic [MAG_W-1:0]         o_magnitude,
    output logic [BYTE_W-1:0]        o_magnitude_byte,
    output logic                     o_frame_end
);

    logic [CFG_WID_W-1:0] r_cfg_width;
    logic [CFG_HGT_W-1:0] r_cfg_height;
    logic                 cfg_wr;
    t_cmd                 cmd;
    t_stat                stat;

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= WIDTH_RST;
            r_cfg_height <= HEIGHT_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_IMAGE_WIDTH:  r_cfg_width  <= pwdata[CFG_WID_W-1:0];
                REG_IMAGE_HEIGHT: r_cfg_height <= pwdata[CFG_HGT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // register read back
    always_comb begin
        unique case (paddr[2])
            REG_IMAGE_WIDTH:  prdata = APB_D_W'(r_cfg_width);
            REG_IMAGE_HEIGHT: prdata = APB_D_W'(r_cfg_height);
            default:          prdata = '0;
        endcase
    end

    pwgm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    pwgm_dpath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_restart        (cfg_wr),
        .i_cfg_width      (r_cfg_width),
        .i_cfg_height     (r_cfg_height),
        .i_pixel          (i_pixel),
        .i_out_ready      (i_out_ready),
        .o_out_valid      (o_out_valid),
        .o_grad_x         (o_grad_x),
        .o_grad_y         (o_grad_y),
        .o_magnitude      (o_magnitude),
        .o_magnitude_byte (o_magnitude_byte),
        .o_frame_end      (o_frame_end)
    );

    // root bounds of the presented result
    logic [31:0] a_sum;
    logic [31:0] a_lo;
    logic [31:0] a_hi;
    always_comb begin
        a_sum = 32'(o_grad_x) * 32'(o_grad_x) + 32'(o_grad_y) * 32'(o_grad_y);
        a_lo  = 32'(o_magnitude) * 32'(o_magnitude);
        a_hi  = (32'(o_magnitude) + 32'd1) * (32'(o_magnitude) + 32'd1);
    end

    // a pixel request keeps the controller busy for at least the window cycle
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready stayed high after a pixel request");

    // magnitude is the floor square root of the sum of the squared gradients
    a_root_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((a_lo <= a_sum) && (a_hi > a_sum)))
        else $error("magnitude is not the floor root of gx^2 + gy^2");

    // byte output is the saturated magnitude
    a_byte_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_magnitude_byte ==
            ((o_magnitude > 11'd255) ? 8'hFF : o_magnitude[7:0])))
        else $error("saturated magnitude mismatch");

endmodule

// ----- test/prewitt_gradient_magnitude_top_tb.sv -----
// testbench for the prewitt gradient magnitude block: scripted frames, random frames, result check
`timescale 1ns / 1ps

module prewitt_gradient_magnitude_top_tb
    import pwgm_pkg::*;
();

    // cycles to let a border pixel or the root pipeline settle before a register write
    localparam int unsigned SETTLE_CYCLES = 24;
    localparam int unsigned RANDOM_PIXELS = 200;

    // one expected or observed result
    typedef struct packed {
        logic signed [GRAD_W-1:0] grad_x;
        logic signed [GRAD_W-1:0] grad_y;
        logic [MAG_W-1:0]         magnitude;
        logic [BYTE_W-1:0]        magnitude_byte;
        logic                     frame_end;
    } t_gradient;

    // one scripted 3x3 frame, raster order, with its result typed in where obvious
    typedef struct packed {
        logic [0:8][PIX_W-1:0] pixels;
        bit                    typed;
        t_gradient             result;
    } t_script_frame;

    typedef enum logic [1:0] {TEX_RANDOM, TEX_BINARY, TEX_FLAT_NOISE, TEX_RAMP} t_texture;
    typedef enum logic [1:0] {DRAIN_FULL, DRAIN_COIN, DRAIN_RUNS} t_drain;

    // full-scale step right, full-scale step left with top bar, then mixed content
    localparam t_script_frame [0:2] DIRECTED_FRAMES = '{
        '{pixels: {8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255},
          typed: 1'b1,
          result: '{grad_x: 11'sd765, grad_y: 11'sd0, magnitude: 11'd765,
                    magnitude_byte: 8'd255, frame_end: 1'b1}},
        '{pixels: {8'd255, 8'd255, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0},
          typed: 1'b1,
          result: '{grad_x: -11'sd765, grad_y: 11'sd255, magnitude: 11'd806,
                    magnitude_byte: 8'd255, frame_end: 1'b1}},
        '{pixels: {8'd17, 8'd200, 8'd93, 8'd255, 8'd0, 8'd128, 8'd64, 8'd1, 8'd250},
          typed: 1'b0,
          result: '0}
    };

    logic                     i_clk;
    logic                     i_rst_n = 1'b0;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [APB_A_W-1:0]       paddr = '0;
    logic [APB_D_W-1:0]       pwdata = '0;
    logic [APB_D_W-1:0]       prdata;
    logic                     pready;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_ready;
    logic [PIX_W-1:0]         i_pixel = '0;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    logic signed [GRAD_W-1:0] o_grad_x;
    logic signed [GRAD_W-1:0] o_grad_y;
    logic [MAG_W-1:0]         o_magnitude;
    logic [BYTE_W-1:0]        o_magnitude_byte;
    logic                     o_frame_end;

    // scripted expectation travelling with the pixel request
    logic                     pixel_has_script = 1'b0;
    t_gradient                pixel_script_result = '0;

    // predictor state: registers, two line stores, window and raster position
    logic [CFG_WID_W-1:0]     cfg_width = WIDTH_RST;
    logic [CFG_HGT_W-1:0]     cfg_height = HEIGHT_RST;
    int                       line_top [MAX_WIDTH_DEF];
    int                       line_mid [MAX_WIDTH_DEF];
    int                       win [3][3];
    int unsigned              col_pos = 0;
    int unsigned              row_pos = 0;

    t_gradient                expected_edges [$];
    int unsigned              error_count = 0;
    int unsigned              burst_left = 0;
    t_drain                   drain_mode = DRAIN_FULL;
    int unsigned              drain_age = 0;
    int unsigned              run_left = 0;

    prewitt_gradient_magnitude_top u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_pixel          (i_pixel),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_grad_x         (o_grad_x),
        .o_grad_y         (o_grad_y),
        .o_magnitude      (o_magnitude),
        .o_magnitude_byte (o_magnitude_byte),
        .o_frame_end      (o_frame_end)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // effective frame size from the register values
    function automatic int unsigned active_width();
        if (cfg_width < 3) return 3;
        if (cfg_width > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
        return cfg_width;
    endfunction

    function automatic int unsigned active_height();
        return (cfg_height < 3) ? 3 : cfg_height;
    endfunction

    // advance the window by one pixel and work out the result for the centre, if any
    task automatic window_step(input logic [PIX_W-1:0] pix, output bit produced,
                               output t_gradient res);
        int unsigned w, h, c, r;
        int          top, mid, gx, gy, sq;
        int unsigned root, trial;
        w = active_width();
        h = active_height();
        c = (col_pos >= w) ? 0 : col_pos;
        r = (row_pos >= h) ? 0 : row_pos;
        top = line_top[c];
        mid = line_mid[c];
        line_top[c] = mid;
        line_mid[c] = pix;
        for (int k = 0; k < 3; k++) begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
        end
        win[0][2] = top;
        win[1][2] = mid;
        win[2][2] = pix;
        produced = (r >= 2) && (c >= 2);
        res = '0;
        if (produced) begin
            gx = 0;
            gy = 0;
            for (int k = 0; k < 3; k++) begin
                gx += win[k][2] - win[k][0];
                gy += win[0][k] - win[2][k];
            end
            sq = gx * gx + gy * gy;
            // square root bit by bit from the top
            root = 0;
            for (int b = MAG_W - 1; b >= 0; b--) begin
                trial = root | (1 << b);
                if (trial * trial <= sq) root = trial;
            end
            res.grad_x         = GRAD_W'(gx);
            res.grad_y         = GRAD_W'(gy);
            res.magnitude      = MAG_W'(root);
            res.magnitude_byte = (root > 255) ? 8'd255 : BYTE_W'(root);
            res.frame_end      = (r == h - 1) && (c == w - 1);
        end
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        col_pos = c;
        row_pos = r;
    endtask

    task automatic compare_field(input string field, input int want, input int got);
        if (want != got) begin
            error_count++;
            $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
        end
    endtask

    // result checking and prediction on accepted requests
    always @(posedge i_clk) begin : watch
        t_gradient want;
        bit        produced;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_edges.size() == 0) begin
                    error_count++;
                    $display("%0t ns: result expected none, got magnitude %0d",
                             $time, o_magnitude);
                end else begin
                    want = expected_edges.pop_front();
                    compare_field("grad_x", $signed(want.grad_x), o_grad_x);
                    compare_field("grad_y", $signed(want.grad_y), o_grad_y);
                    compare_field("magnitude", want.magnitude, o_magnitude);
                    compare_field("magnitude_byte", want.magnitude_byte, o_magnitude_byte);
                    compare_field("frame_end", want.frame_end, o_frame_end);
                end
            end
            if (i_in_valid && o_in_ready) begin
                window_step(i_pixel, produced, want);
                if (pixel_has_script) expected_edges.push_back(pixel_script_result);
                else if (produced) expected_edges.push_back(want);
            end
        end
    end

    // receiver: always ready, coin toss, or alternating runs of ready and stall
    always @(posedge i_clk) begin
        drain_age++;
        if (drain_age % 200 == 0) drain_mode = t_drain'($urandom_range(0, 2));
        case (drain_mode)
            DRAIN_FULL: begin
                i_out_ready <= 1'b1;
            end
            DRAIN_COIN: begin
                i_out_ready <= ($urandom_range(0, 1) == 1);
            end
            default: begin
                if (run_left == 0) begin
                    run_left = $urandom_range(1, 30);
                    i_out_ready <= ~i_out_ready;
                end else begin
                    run_left--;
                end
            end
        endcase
    end

    // one pixel request, with a random gap at the start of each burst
    task automatic send_pixel(input logic [PIX_W-1:0] pix, input bit scripted,
                              input t_gradient scripted_res);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            gap = $urandom_range(1, 9);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        burst_left--;
        i_in_valid          <= 1'b1;
        i_pixel             <= pix;
        pixel_has_script    <= scripted;
        pixel_script_result <= scripted_res;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // stop sending, wait for every result, then let the pipeline settle
    task automatic drain_results();
        i_in_valid <= 1'b0;
        burst_left = 0;
        // let the last request reach the predictor first
        @(posedge i_clk);
        while (expected_edges.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic read_register(input logic reg_sel, input logic [APB_D_W-1:0] want);
        logic [APB_D_W-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {reg_sel, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(negedge i_clk);
            got = prdata;
        end while (!pready);
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        if (got !== want) begin
            error_count++;
            $display("%0t ns: register %0d read expected %0d, got %0d",
                     $time, reg_sel, want, got);
        end
    endtask

    // write a register with noise above the field, mirror it, read it back
    task automatic program_register(input logic reg_sel, input int unsigned value);
        logic [APB_D_W-1:0] wdata;
        logic [APB_D_W-1:0] kept;
        wdata = $urandom();
        if (reg_sel == REG_IMAGE_WIDTH) begin
            wdata[CFG_WID_W-1:0] = CFG_WID_W'(value);
            kept = APB_D_W'(wdata[CFG_WID_W-1:0]);
        end else begin
            wdata[CFG_HGT_W-1:0] = CFG_HGT_W'(value);
            kept = APB_D_W'(wdata[CFG_HGT_W-1:0]);
        end
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // any write restarts the frame
        if (reg_sel == REG_IMAGE_WIDTH) cfg_width = wdata[CFG_WID_W-1:0];
        else cfg_height = wdata[CFG_HGT_W-1:0];
        col_pos = 0;
        row_pos = 0;
        @(posedge i_clk);
        read_register(reg_sel, kept);
    endtask

    function automatic logic [PIX_W-1:0] make_pixel(input t_texture tex, input int unsigned idx,
                                                    input logic [PIX_W-1:0] level);
        int v;
        case (tex)
            TEX_BINARY: begin
                return ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
            end
            TEX_FLAT_NOISE: begin
                v = int'(level) + $urandom_range(0, 6) - 3;
                return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : PIX_W'(v);
            end
            TEX_RAMP: begin
                return PIX_W'(level + idx * 7);
            end
            default: begin
                return PIX_W'($urandom_range(0, 255));
            end
        endcase
    endfunction

    // a run of pixel requests of one texture, then drain
    task automatic run_phase(input int unsigned count, input t_texture tex);
        logic [PIX_W-1:0] level;
        level = $urandom_range(0, 255);
        for (int unsigned n = 0; n < count; n++) send_pixel(make_pixel(tex, n, level), 1'b0, '0);
        drain_results();
    endtask

    // stimulus
    initial begin : stimulus
        int unsigned random_pixels;
        int unsigned pick;
        int unsigned w, h, count;
        random_pixels = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values, then smallest frame with scripted content across frame wraps
        read_register(REG_IMAGE_WIDTH, APB_D_W'(WIDTH_RST));
        read_register(REG_IMAGE_HEIGHT, APB_D_W'(HEIGHT_RST));
        program_register(REG_IMAGE_WIDTH, 3);
        program_register(REG_IMAGE_HEIGHT, 3);
        for (int f = 0; f < 3; f++) begin
            for (int k = 0; k < 9; k++) begin
                send_pixel(DIRECTED_FRAMES[f].pixels[k], DIRECTED_FRAMES[f].typed && k == 8,
                           DIRECTED_FRAMES[f].result);
            end
        end
        drain_results();

        // zero registers fall back to the minimum frame
        program_register(REG_IMAGE_WIDTH, 0);
        program_register(REG_IMAGE_HEIGHT, 0);
        run_phase(18, TEX_BINARY);

        // oversized width clamps to the widest line, wrap into the next line, tall frame unfinished
        program_register(REG_IMAGE_WIDTH, 2047);
        program_register(REG_IMAGE_HEIGHT, 65535);
        run_phase(MAX_WIDTH_DEF + 40, TEX_RANDOM);

        // random frame sizes, whole frames mostly, broken frames now and then
        while (random_pixels < RANDOM_PIXELS) begin
            pick = $urandom_range(0, 3);
            if (pick != 1) begin
                case ($urandom_range(0, 9))
                    0:             program_register(REG_IMAGE_WIDTH, $urandom_range(0, 2));
                    1, 2, 3, 4, 5, 6: program_register(REG_IMAGE_WIDTH, $urandom_range(3, 8));
                    default:       program_register(REG_IMAGE_WIDTH, $urandom_range(9, 40));
                endcase
            end
            if (pick != 0) begin
                case ($urandom_range(0, 9))
                    0:       program_register(REG_IMAGE_HEIGHT, $urandom_range(0, 2));
                    1:       program_register(REG_IMAGE_HEIGHT, 65535);
                    default: program_register(REG_IMAGE_HEIGHT, $urandom_range(3, 7));
                endcase
            end
            w = active_width();
            h = active_height();
            if (h > 64) count = w * $urandom_range(3, 6) + $urandom_range(0, w - 1);
            else if ($urandom_range(0, 9) < 7) count = w * h * $urandom_range(1, 3);
            else count = $urandom_range(1, 2 * w * h);
            run_phase(count, t_texture'($urandom_range(0, 3)));
            random_pixels += count;
        end

        if (error_count == 0) $display("prewitt_gradient_magnitude_top: match");
        else $display("prewitt_gradient_magnitude_top: mismatch");
        $finish;
    end

    // watchdog
    initial begin
        #4000000;
        $display("prewitt_gradient_magnitude_top: mismatch");
        $finish;
    end

endmodule
